FILE: rtl/pbscm_pkg.sv
// pbscm_pkg: shared types, constants and helpers for the pci bus scan block
`timescale 1ns / 1ps
package pbscm_pkg;

  // scan extent
  localparam int SLOTS     = 32;
  localparam int FUNCTIONS = 8;

  localparam int SLOT_W = 5;
  localparam int FUNC_W = 3;

  // configuration register indexes
  localparam logic [7:0] CFG_BUS_NUMBER      = 8'd0;
  localparam logic [7:0] CFG_MATCH_CLASS     = 8'd1;
  localparam logic [7:0] CFG_MATCH_SUBCLASS  = 8'd2;
  localparam logic [7:0] CFG_MATCH_INTERFACE = 8'd3;

  // configuration register reset values
  localparam logic [7:0] RST_BUS_NUMBER      = 8'h00;
  localparam logic [7:0] RST_MATCH_CLASS     = 8'h0C;
  localparam logic [7:0] RST_MATCH_SUBCLASS  = 8'h03;
  localparam logic [7:0] RST_MATCH_INTERFACE = 8'h30;

  // config space register offsets
  localparam logic [7:0] REG_ID     = 8'h00;
  localparam logic [7:0] REG_CLASS  = 8'h08;
  localparam logic [7:0] REG_HEADER = 8'h0C;
  localparam logic [7:0] REG_BAR0   = 8'h10;
  localparam logic [7:0] REG_BAR1   = 8'h14;

  localparam logic [15:0] VENDOR_NONE_HI = 16'hFFFF;
  localparam logic [15:0] VENDOR_NONE_LO = 16'h0000;
  localparam logic [31:0] BAR_MASK       = 32'hFFFF_FFF0;
  localparam logic [31:0] CFG_ENABLE     = 32'h8000_0000;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    RK_READ    = 2'd0,
    RK_FOUND   = 2'd1,
    RK_NONE    = 2'd2,
    RK_IGNORED = 2'd3
  } rk_t;

  typedef struct packed {
    logic [7:0] bus_number;
    logic [7:0] match_class;
    logic [7:0] match_subclass;
    logic [7:0] match_interface;
  } cfg_t;

  typedef struct packed {
    rk_t         result_kind;
    logic [31:0] config_address;
    logic [15:0] vendor_id;
    logic [15:0] device_id;
    logic [63:0] base_address;
  } res_t;

  // mechanism 1 address word
  function automatic logic [31:0] make_addr(input logic [7:0]        bus,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [FUNC_W-1:0] fn,
                                            input logic [7:0]        offs);
    make_addr = CFG_ENABLE | {8'h00, bus, slot, fn, offs & 8'hFC};
  endfunction

endpackage

FILE: rtl/pbscm_in_if.sv
// pbscm_in_if: input channel carrying start items and returned config dwords
`timescale 1ns / 1ps
interface pbscm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] read_data;

  modport source (output valid, output kind, output read_data, input ready);
  modport sink   (input valid, input kind, input read_data, output ready);
endinterface

FILE: rtl/pbscm_out_if.sv
// pbscm_out_if: result channel carrying read requests and scan reports
`timescale 1ns / 1ps
interface pbscm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] config_address;
  logic [15:0] vendor_id;
  logic [15:0] device_id;
  logic [63:0] base_address;

  modport source (output valid, output result_kind, output config_address,
                  output vendor_id, output device_id, output base_address,
                  input ready);
  modport sink   (input valid, input result_kind, input config_address,
                  input vendor_id, input device_id, input base_address,
                  output ready);
endinterface

FILE: rtl/pbscm_cfg.sv
// pbscm_cfg: configuration register file for bus number and class match
`timescale 1ns / 1ps
module pbscm_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  output pbscm_pkg::cfg_t     cfg
);

  pbscm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_number      <= pbscm_pkg::RST_BUS_NUMBER;
      cfg_r.match_class     <= pbscm_pkg::RST_MATCH_CLASS;
      cfg_r.match_subclass  <= pbscm_pkg::RST_MATCH_SUBCLASS;
      cfg_r.match_interface <= pbscm_pkg::RST_MATCH_INTERFACE;
    end else if (cfg_we) begin
      case (cfg_index)
        pbscm_pkg::CFG_BUS_NUMBER:      cfg_r.bus_number      <= cfg_wdata;
        pbscm_pkg::CFG_MATCH_CLASS:     cfg_r.match_class     <= cfg_wdata;
        pbscm_pkg::CFG_MATCH_SUBCLASS:  cfg_r.match_subclass  <= cfg_wdata;
        pbscm_pkg::CFG_MATCH_INTERFACE: cfg_r.match_interface <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/pbscm_walk.sv
// pbscm_walk: scan state machine, one transition per accepted item
`timescale 1ns / 1ps
module pbscm_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                kind,
  input  logic [31:0]         read_data,
  input  pbscm_pkg::cfg_t     cfg,
  output pbscm_pkg::res_t     res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_VID  = 3'd1,
    PH_CC   = 3'd2,
    PH_BAR0 = 3'd3,
    PH_BAR1 = 3'd4,
    PH_HDR  = 3'd5
  } phase_t;

  phase_t                         phase_r,  phase_nxt;
  logic [pbscm_pkg::SLOT_W-1:0]   slot_r,   slot_nxt;
  logic [pbscm_pkg::FUNC_W-1:0]   func_r,   func_nxt;
  logic [31:0]                    id_r,     id_nxt;
  logic [31:0]                    base_r,   base_nxt;

  logic [pbscm_pkg::SLOT_W:0]     slot_inc;
  logic [pbscm_pkg::FUNC_W:0]     func_inc;
  logic                           last_slot, last_func;
  logic                           class_hit, vendor_none;
  logic                           adv_func, adv_slot, req;
  logic [7:0]                     req_reg;
  logic [31:0]                    bar_low;

  assign slot_inc    = {1'b0, slot_r} + 1'b1;
  assign func_inc    = {1'b0, func_r} + 1'b1;
  assign last_slot   = slot_inc >= (pbscm_pkg::SLOT_W + 1)'(pbscm_pkg::SLOTS);
  assign last_func   = func_inc >= (pbscm_pkg::FUNC_W + 1)'(pbscm_pkg::FUNCTIONS);
  assign class_hit   = (read_data[31:24] == cfg.match_class)
                    && (read_data[23:16] == cfg.match_subclass)
                    && (read_data[15:8]  == cfg.match_interface);
  assign vendor_none = (read_data[15:0] == pbscm_pkg::VENDOR_NONE_HI)
                    || (read_data[15:0] == pbscm_pkg::VENDOR_NONE_LO);
  assign bar_low     = read_data & pbscm_pkg::BAR_MASK;

  always_comb begin
    phase_nxt = phase_r;
    slot_nxt  = slot_r;
    func_nxt  = func_r;
    id_nxt    = id_r;
    base_nxt  = base_r;
    adv_func  = 1'b0;
    adv_slot  = 1'b0;
    req       = 1'b0;
    req_reg   = pbscm_pkg::REG_ID;
    res       = '0;
    res.result_kind = pbscm_pkg::RK_IGNORED;

    if (kind == pbscm_pkg::KIND_START) begin
      slot_nxt  = '0;
      func_nxt  = '0;
      id_nxt    = '0;
      base_nxt  = '0;
      req       = 1'b1;
      phase_nxt = PH_VID;
    end else begin
      case (phase_r)
        PH_VID: begin
          if (vendor_none) begin
            adv_slot = 1'b1;
          end else begin
            id_nxt    = read_data;
            req       = 1'b1;
            req_reg   = pbscm_pkg::REG_CLASS;
            phase_nxt = PH_CC;
          end
        end
        PH_CC: begin
          if (class_hit) begin
            req       = 1'b1;
            req_reg   = pbscm_pkg::REG_BAR0;
            phase_nxt = PH_BAR0;
          end else if (func_r == '0) begin
            req       = 1'b1;
            req_reg   = pbscm_pkg::REG_HEADER;
            phase_nxt = PH_HDR;
          end else begin
            adv_func = 1'b1;
          end
        end
        PH_BAR0: begin
          base_nxt = bar_low;
          if (read_data[2]) begin
            req       = 1'b1;
            req_reg   = pbscm_pkg::REG_BAR1;
            phase_nxt = PH_BAR1;
          end else begin
            phase_nxt        = PH_IDLE;
            res.result_kind  = pbscm_pkg::RK_FOUND;
            res.vendor_id    = id_r[15:0];
            res.device_id    = id_r[31:16];
            res.base_address = {32'h0, bar_low};
          end
        end
        PH_BAR1: begin
          phase_nxt        = PH_IDLE;
          res.result_kind  = pbscm_pkg::RK_FOUND;
          res.vendor_id    = id_r[15:0];
          res.device_id    = id_r[31:16];
          res.base_address = {read_data, base_r};
        end
        PH_HDR: begin
          if (read_data[31]) adv_func = 1'b1;
          else               adv_slot = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // move on to the next function, or the next slot past the last one
      if (adv_func) begin
        if (last_func) begin
          adv_slot = 1'b1;
        end else begin
          func_nxt  = func_inc[pbscm_pkg::FUNC_W-1:0];
          req       = 1'b1;
          phase_nxt = PH_VID;
        end
      end
      if (adv_slot) begin
        if (last_slot) begin
          phase_nxt       = PH_IDLE;
          res.result_kind = pbscm_pkg::RK_NONE;
        end else begin
          slot_nxt  = slot_inc[pbscm_pkg::SLOT_W-1:0];
          func_nxt  = '0;
          req       = 1'b1;
          phase_nxt = PH_VID;
        end
      end
    end

    if (req) begin
      res.result_kind    = pbscm_pkg::RK_READ;
      res.config_address = pbscm_pkg::make_addr(cfg.bus_number, slot_nxt,
                                                 func_nxt, req_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      slot_r  <= '0;
      func_r  <= '0;
      id_r    <= '0;
      base_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      func_r  <= func_nxt;
      id_r    <= id_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

FILE: rtl/pci_bus_scan_class_match.sv
// pci_bus_scan_class_match: top level of the pci config space class scanner
`timescale 1ns / 1ps
// timing: an input transfer's result appears in the output register in the next cycle
// throughput: one item per cycle while out_ch is ready, one result per item, set by the single
//   output register that drains and refills in the same cycle
// reset: synchronous active-low rst_n returns the walk to idle, clears the
//   output valid flag and loads the match registers with class 0c/03/30, bus 0
module pci_bus_scan_class_match (
  input  logic        clk,
  input  logic        rst_n,
  pbscm_in_if.sink    in_ch,
  pbscm_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  pbscm_pkg::cfg_t cfg;
  pbscm_pkg::res_t res;
  pbscm_pkg::res_t res_r;
  logic            out_valid_r;
  logic            in_xfer;

  // match and bus registers
  pbscm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // accept whenever the output register is empty or being drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // scan walk: state advances only on an input transfer
  pbscm_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_xfer),
    .kind      (in_ch.kind),
    .read_data (in_ch.read_data),
    .cfg       (cfg),
    .res       (res)
  );

  // output register, exactly one result per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset, only loads on a transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = res_r.result_kind;
  assign out_ch.config_address = res_r.config_address;
  assign out_ch.vendor_id      = res_r.vendor_id;
  assign out_ch.device_id      = res_r.device_id;
  assign out_ch.base_address   = res_r.base_address;

endmodule
